// ----- hw/rtl/gasp_pkg.sv -----
// Package for the grid path search block: payload structs, FSM state, command bundles.
// No dependencies.
`default_nettype none
package gasp_pkg;

    typedef struct packed {
        logic       opcode;
        logic [2:0] cell_row;
        logic [2:0] cell_col;
        logic       cell_open;
    } in_item_t;

    typedef struct packed {
        logic [2:0] path_row;
        logic [2:0] path_col;
        logic       found;
        logic       last_cell;
    } out_item_t;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    localparam logic [1:0] REG_START_ROW = 2'd0;
    localparam logic [1:0] REG_START_COL = 2'd1;
    localparam logic [1:0] REG_DEST_ROW  = 2'd2;
    localparam logic [1:0] REG_DEST_COL  = 2'd3;

    localparam logic [9:0] STEP_STRAIGHT = 10'd10;
    localparam logic [9:0] STEP_DIAG     = 10'd14;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_SCAN_END,
        ST_NBR,
        ST_NBR_RD,
        ST_NBR_UPD,
        ST_WALK_RD,
        ST_WALK_OUT,
        ST_SINGLE
    } state_t;

    typedef struct packed {
        logic load;       // write grid cell from input beat
        logic clear;      // clear open/closed sweep step
        logic init;       // set up start cell
        logic scan_step;  // compare one cell in min search
        logic scan_start;
        logic take_best;  // move best cell to closed
        logic nbr_rd;     // issue reads for current neighbor
        logic nbr_upd;    // write neighbor if improved
        logic nbr_next;
        logic walk_init;
        logic walk_rd;
        logic walk_emit;
        logic single;     // emit single result
    } cmd_t;

    typedef struct packed {
        logic bad_coord;
        logic same_cell;
        logic clear_done;
        logic scan_done;
        logic none_open;
        logic nbr_done;
        logic nbr_skip;   // out of grid, blocked or closed
        logic nbr_dest;
        logic walk_last;
        logic out_busy;
    } status_t;

    // floor(sqrt(n)) for n = 100*(dr^2+dc^2), dr,dc <= 7: table by (dr,dc)
    function automatic logic [6:0] heur_lut(input logic [2:0] dr, input logic [2:0] dc);
        logic [6:0] s;
        logic [13:0] n;
        n = 14'(100 * (int'(dr) * int'(dr) + int'(dc) * int'(dc)));
        s = 7'd0;
        for (int k = 1; k < 100; k++) begin
            if (14'(k * k) <= n) s = 7'(k);
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/grid_astar_path_search.sv -----
// Grid A* search, 8-connected. Load beats write one grid cell each.
// Run: a clear step, then per expansion a min scan over all cells, a read and an optional
// update per neighbor and a restart of the scan; then a read and an emit per path cell.
// One item at a time.
// Reset: async active-low; registers take start (0,0), dest (7,7); grid undefined.
// Depends on gasp_pkg, gasp_ctrl, gasp_dp.
`default_nettype none
module grid_astar_path_search #(
    parameter int GRID_ROWS = 8,
    parameter int GRID_COLS = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire gasp_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output gasp_pkg::out_item_t      out_data,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [2:0]          cfg_data
);
    import gasp_pkg::*;

    logic [2:0] start_row_reg, start_col_reg, dest_row_reg, dest_col_reg;
    cmd_t    cmd;
    status_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_row_reg <= 3'd0;
            start_col_reg <= 3'd0;
            dest_row_reg  <= 3'd7;
            dest_col_reg  <= 3'd7;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_START_ROW: start_row_reg <= cfg_data;
                REG_START_COL: start_col_reg <= cfg_data;
                REG_DEST_ROW:  dest_row_reg  <= cfg_data;
                REG_DEST_COL:  dest_col_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    wire logic in_fire = in_valid && !in_stall;

    gasp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_op(in_data.opcode),
        .sts(sts), .cmd(cmd), .in_stall(in_stall)
    );

    gasp_dp #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_item(in_data),
        .start_row(start_row_reg), .start_col(start_col_reg),
        .dest_row(dest_row_reg), .dest_col(dest_col_reg),
        .cmd(cmd), .sts(sts), .out_item(out_data), .out_valid(out_valid),
        .out_stall(out_stall)
    );
endmodule
`default_nettype wire

// ----- hw/rtl/gasp_ctrl.sv -----
// Controller FSM for the grid path search.
// Depends on gasp_pkg.
`default_nettype none
module gasp_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_fire,
    input  wire logic             in_op,
    input  wire gasp_pkg::status_t sts,
    output gasp_pkg::cmd_t        cmd,
    output logic                  in_stall
);
    import gasp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= ST_IDLE;
        else        state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire && in_op == OP_RUN) begin
                    if (sts.bad_coord || sts.same_cell) state_next = ST_SINGLE;
                    else state_next = ST_CLEAR;
                end
            ST_CLEAR:    if (sts.clear_done) state_next = ST_SCAN;
            ST_SCAN:     if (sts.scan_done) state_next = ST_SCAN_END;
            ST_SCAN_END: state_next = sts.none_open ? ST_SINGLE : ST_NBR;
            ST_NBR:
                if (sts.nbr_done) state_next = ST_SCAN;
                else state_next = ST_NBR_RD;
            ST_NBR_RD:
                if (sts.nbr_skip) state_next = ST_NBR;
                else if (sts.nbr_dest) state_next = ST_WALK_RD;
                else state_next = ST_NBR_UPD;
            ST_NBR_UPD:  state_next = ST_NBR;
            ST_WALK_RD:  state_next = ST_WALK_OUT;
            ST_WALK_OUT:
                if (!sts.out_busy) state_next = sts.walk_last ? ST_IDLE : ST_WALK_RD;
            ST_SINGLE:   if (!sts.out_busy) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_fire && in_op == OP_LOAD;
                cmd.clear = in_fire && in_op == OP_RUN;
            end
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                cmd.init = sts.clear_done;
                cmd.scan_start = sts.clear_done;
            end
            ST_SCAN:     cmd.scan_step = 1'b1;
            ST_SCAN_END: cmd.take_best = !sts.none_open;
            ST_NBR:
            begin
                cmd.nbr_rd = !sts.nbr_done;
                cmd.scan_start = sts.nbr_done;
            end
            ST_NBR_RD:
            begin
                cmd.nbr_next = sts.nbr_skip;
                cmd.walk_init = !sts.nbr_skip && sts.nbr_dest;
            end
            ST_NBR_UPD:
            begin
                cmd.nbr_upd = 1'b1;
                cmd.nbr_next = 1'b1;
            end
            ST_WALK_RD:  cmd.walk_rd = 1'b1;
            ST_WALK_OUT: cmd.walk_emit = !sts.out_busy;
            ST_SINGLE:   cmd.single = !sts.out_busy;
            default:     cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

// ----- hw/rtl/gasp_dp.sv -----
// Datapath: grid store, per-cell search memories, min scan, neighbor update, path walk.
// Depends on gasp_pkg.
`default_nettype none
module gasp_dp #(
    parameter int GRID_ROWS = 8,
    parameter int GRID_COLS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gasp_pkg::in_item_t in_item,
    input  wire logic [2:0]         start_row,
    input  wire logic [2:0]         start_col,
    input  wire logic [2:0]         dest_row,
    input  wire logic [2:0]         dest_col,
    input  wire gasp_pkg::cmd_t     cmd,
    output gasp_pkg::status_t       sts,
    output gasp_pkg::out_item_t     out_item,
    output logic                    out_valid,
    input  wire logic               out_stall
);
    import gasp_pkg::*;

    // memories, indexed {row,col}
    logic        pass_mem [64];
    logic [9:0]  g_mem    [64];
    logic [9:0]  f_mem    [64];
    logic [5:0]  link_mem [64];
    logic [11:0] stamp_mem[64];
    logic [63:0] open_reg, closed_reg;

    logic [6:0]  idx_reg;      // scan counter
    logic        best_ok_reg;
    logic [5:0]  best_reg;
    logic [9:0]  best_f_reg;
    logic [11:0] best_s_reg;
    logic [5:0]  cur_reg;
    logic [9:0]  cur_g_reg;
    logic [3:0]  dir_reg;
    logic [11:0] stamp_cnt_reg;
    logic        nbr_ok_reg;   // neighbor in grid, passable, not closed
    logic [5:0]  ni_reg;
    logic [9:0]  ng_reg, nf_reg;
    logic [9:0]  old_g_reg, old_f_reg;
    logic [5:0]  walk_reg;
    logic [6:0]  walk_cnt_reg;
    logic [5:0]  walk_link_reg;
    logic [9:0]  sf_reg;
    logic [11:0] ss_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;

    wire logic [5:0] si = {start_row, start_col};
    wire logic [5:0] di = {dest_row, dest_col};

    assign sts.bad_coord = (32'(start_row) >= GRID_ROWS) || (32'(start_col) >= GRID_COLS)
                        || (32'(dest_row) >= GRID_ROWS) || (32'(dest_col) >= GRID_COLS);
    assign sts.same_cell = (si == di);
    assign sts.clear_done = 1'b1;
    assign sts.scan_done = idx_reg[6];
    assign sts.none_open = !best_ok_reg;
    assign sts.nbr_done = dir_reg[3];
    assign sts.nbr_skip = !nbr_ok_reg;
    assign sts.nbr_dest = (ni_reg == di);
    assign sts.walk_last = (walk_reg == si) || (walk_cnt_reg == 7'd63);
    assign sts.out_busy = out_valid_reg && out_stall;

    // neighbor geometry for dir_reg
    logic signed [4:0] nr, nc;
    logic [2:0] dr, dc;
    logic       in_grid;
    logic [5:0] ni;
    always_comb
    begin
        nr = 5'(signed'({2'b0, cur_reg[5:3]}));
        nc = 5'(signed'({2'b0, cur_reg[2:0]}));
        case (dir_reg[2:0])
            3'd0: nc = nc + 5'sd1;
            3'd1: begin nr = nr + 5'sd1; nc = nc + 5'sd1; end
            3'd2: nr = nr + 5'sd1;
            3'd3: begin nr = nr + 5'sd1; nc = nc - 5'sd1; end
            3'd4: nc = nc - 5'sd1;
            3'd5: begin nr = nr - 5'sd1; nc = nc - 5'sd1; end
            3'd6: nr = nr - 5'sd1;
            default: begin nr = nr - 5'sd1; nc = nc + 5'sd1; end
        endcase
        in_grid = (nr >= 0) && (nc >= 0) && (32'(nr) < GRID_ROWS) && (32'(nc) < GRID_COLS);
        ni = {nr[2:0], nc[2:0]};
        dr = (nr[2:0] > dest_row) ? nr[2:0] - dest_row : dest_row - nr[2:0];
        dc = (nc[2:0] > dest_col) ? nc[2:0] - dest_col : dest_col - nc[2:0];
    end

    wire logic [9:0] ng_c = cur_g_reg + (dir_reg[0] ? STEP_DIAG : STEP_STRAIGHT);
    wire logic [9:0] nf_c = ng_c + 10'(heur_lut(dr, dc));
    wire logic improve = !open_reg[ni_reg] || (nf_reg < old_f_reg)
                      || (nf_reg == old_f_reg && ng_reg <= old_g_reg);

    wire logic [5:0] sidx = idx_reg[5:0];
    wire logic better = open_reg[sidx] &&
        (!best_ok_reg || sf_reg < best_f_reg || (sf_reg == best_f_reg && ss_reg > best_s_reg));

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.load && 32'(in_item.cell_row) < GRID_ROWS && 32'(in_item.cell_col) < GRID_COLS)
            pass_mem[{in_item.cell_row, in_item.cell_col}] <= in_item.cell_open;
        if (cmd.init) begin
            g_mem[si] <= '0;
            f_mem[si] <= '0;
            stamp_mem[si] <= '0;
        end
        if (cmd.nbr_upd && improve) begin
            g_mem[ni_reg] <= ng_reg;
            f_mem[ni_reg] <= nf_reg;
            stamp_mem[ni_reg] <= stamp_cnt_reg + 12'd1;
        end
        if ((cmd.nbr_upd && improve) || cmd.walk_init)
            link_mem[ni_reg] <= cur_reg;
    end

    // registered reads
    always_ff @(posedge clk)
    begin
        sf_reg <= f_mem[cmd.scan_start ? 6'd0 : 6'(idx_reg + 7'd1)];
        ss_reg <= stamp_mem[cmd.scan_start ? 6'd0 : 6'(idx_reg + 7'd1)];
        old_g_reg <= g_mem[ni];
        old_f_reg <= f_mem[ni];
        walk_link_reg <= link_mem[walk_reg];
        cur_g_reg <= g_mem[cmd.take_best ? best_reg : cur_reg];
        nbr_ok_reg <= in_grid && pass_mem[ni] && !closed_reg[ni];
        ni_reg <= ni;
        ng_reg <= ng_c;
        nf_reg <= nf_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            open_reg <= '0;
            closed_reg <= '0;
            idx_reg <= '0;
            best_ok_reg <= 1'b0;
            dir_reg <= '0;
            stamp_cnt_reg <= '0;
            walk_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && !out_stall) out_valid_reg <= 1'b0;
            if (cmd.clear) begin
                open_reg <= '0;
                closed_reg <= '0;
                stamp_cnt_reg <= '0;
            end
            if (cmd.init) open_reg[si] <= 1'b1;
            if (cmd.scan_start) begin
                idx_reg <= '0;
                best_ok_reg <= 1'b0;
            end
            if (cmd.scan_step) begin
                idx_reg <= idx_reg + 7'd1;
                if (better) best_ok_reg <= 1'b1;
            end
            if (cmd.take_best) begin
                open_reg[best_reg] <= 1'b0;
                closed_reg[best_reg] <= 1'b1;
                dir_reg <= '0;
            end
            if (cmd.nbr_next) dir_reg <= dir_reg + 4'd1;
            if (cmd.nbr_upd && improve) begin
                open_reg[ni_reg] <= 1'b1;
                stamp_cnt_reg <= stamp_cnt_reg + 12'd1;
            end
            if (cmd.walk_init) walk_cnt_reg <= '0;
            if (cmd.walk_emit) walk_cnt_reg <= walk_cnt_reg + 7'd1;
            if (cmd.walk_emit || cmd.single) out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && better) begin
            best_reg <= sidx;
            best_f_reg <= sf_reg;
            best_s_reg <= ss_reg;
        end
        if (cmd.take_best) cur_reg <= best_reg;
        if (cmd.walk_init) walk_reg <= di;
        if (cmd.walk_emit) begin
            out_reg <= '{walk_reg[5:3], walk_reg[2:0], 1'b1, sts.walk_last};
            walk_reg <= walk_link_reg;
        end
        if (cmd.single) begin
            if (sts.bad_coord || !best_ok_reg && !sts.same_cell)
                out_reg <= '{3'd0, 3'd0, 1'b0, 1'b1};
            else
                out_reg <= '{start_row, start_col, 1'b1, 1'b1};
        end
    end

    assign out_item = out_reg;
    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

// ----- sim/grid_astar_path_search_tb.sv -----
// Self-checking testbench for grid_astar_path_search: grid loads and A* runs,
// path beats checked against an in-bench search predictor. Depends on gasp_pkg.
`default_nettype none
module grid_astar_path_search_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gasp_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [2:0] cfg_data;

    grid_astar_path_search dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // predictor state
    logic [2:0] p_srow, p_scol, p_drow, p_dcol;
    logic       grid_open [64];
    logic       open_set [64];
    logic       closed_set [64];
    logic [9:0] g_cost [64];
    logic [9:0] f_cost [64];
    logic [5:0] parent [64];
    logic [11:0] stamp [64];
    logic [11:0] stamp_ctr;

    out_item_t path_q[$];
    int errors;
    int mism;
    int cycles;
    int send_idle_pct;
    int recv_stall_pct;
    bit long_hold;
    bit cfg_busy;
    bit done_flag;

    function automatic logic [9:0] heuristic(int r, int c);
        int dr, dc, n, s;
        dr = (r > p_drow) ? r - p_drow : p_drow - r;
        dc = (c > p_dcol) ? c - p_dcol : p_dcol - c;
        n = 100 * (dr * dr + dc * dc);
        s = 0;
        while ((s + 1) * (s + 1) <= n) s++;
        return 10'(s);
    endfunction

    function automatic out_item_t mk(int r, int c, bit fnd, bit last);
        out_item_t o;
        o.path_row = 3'(r);
        o.path_col = 3'(c);
        o.found = fnd;
        o.last_cell = last;
        return o;
    endfunction

    task automatic predict_search();
        int si, di, cur, best, nr, nc, ni, k, c;
        int dr [8];
        int dc [8];
        bit reached;
        bit last;
        logic [9:0] ng, nf;
        dr = '{0, 1, 1, 1, 0, -1, -1, -1};
        dc = '{1, 1, 0, -1, -1, -1, 0, 1};
        reached = 0;
        if (p_srow == p_drow && p_scol == p_dcol)
        begin
            path_q.push_back(mk(p_srow, p_scol, 1, 1));
            return;
        end
        si = p_srow * 8 + p_scol;
        di = p_drow * 8 + p_dcol;
        for (int i = 0; i < 64; i++)
        begin
            open_set[i] = 0;
            closed_set[i] = 0;
        end
        stamp_ctr = 0;
        open_set[si] = 1;
        g_cost[si] = 0;
        f_cost[si] = 0;
        stamp[si] = 0;
        while (!reached)
        begin
            best = -1;
            for (int i = 0; i < 64; i++)
                if (open_set[i] && (best < 0 || f_cost[i] < f_cost[best] ||
                    (f_cost[i] == f_cost[best] && stamp[i] > stamp[best])))
                    best = i;
            if (best < 0)
            begin
                path_q.push_back(mk(0, 0, 0, 1));
                return;
            end
            cur = best;
            open_set[cur] = 0;
            closed_set[cur] = 1;
            for (int d = 0; d < 8; d++)
            begin
                nr = cur / 8 + dr[d];
                nc = cur % 8 + dc[d];
                if (nr < 0 || nc < 0 || nr > 7 || nc > 7) continue;
                ni = nr * 8 + nc;
                if (!grid_open[ni] || closed_set[ni]) continue;
                if (ni == di)
                begin
                    parent[di] = 6'(cur);
                    reached = 1;
                    break;
                end
                ng = g_cost[cur] + ((d % 2) ? STEP_DIAG : STEP_STRAIGHT);
                nf = ng + heuristic(nr, nc);
                if (open_set[ni] && !(nf < f_cost[ni] ||
                    (nf == f_cost[ni] && ng <= g_cost[ni])))
                    continue;
                stamp_ctr = stamp_ctr + 1;
                g_cost[ni] = ng;
                f_cost[ni] = nf;
                parent[ni] = 6'(cur);
                stamp[ni] = stamp_ctr;
                open_set[ni] = 1;
            end
        end
        c = di;
        for (k = 0; k < 64; k++)
        begin
            last = (c == si) || (k == 63);
            path_q.push_back(mk(c / 8, c % 8, 1, last));
            if (last) break;
            c = parent[c];
        end
    endtask

    // valid stays high on return; the next beat, an idle cycle or drain() drops it
    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (it.opcode == OP_LOAD)
            grid_open[it.cell_row * 8 + it.cell_col] = it.cell_open;
        else
            predict_search();
    endtask

    task automatic load_cell(int r, int c, bit o);
        in_item_t it;
        it.opcode = OP_LOAD;
        it.cell_row = 3'(r);
        it.cell_col = 3'(c);
        it.cell_open = o;
        send_item(it);
    endtask

    task automatic run_search();
        in_item_t it;
        it = '0;
        it.opcode = OP_RUN;
        it.cell_row = 3'($urandom);
        it.cell_col = 3'($urandom);
        it.cell_open = 1'($urandom);
        send_item(it);
    endtask

    // drop valid, wait until no path beats are expected, then idle between phases
    task automatic drain();
        in_valid <= 1'b0;
        while (path_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [2:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_START_ROW: p_srow = val;
            REG_START_COL: p_scol = val;
            REG_DEST_ROW: p_drow = val;
            default: p_dcol = val;
        endcase
    endtask

    task automatic set_route(int sr, int sc, int dr, int dc);
        drain();
        write_reg(REG_START_ROW, 3'(sr));
        write_reg(REG_START_COL, 3'(sc));
        write_reg(REG_DEST_ROW, 3'(dr));
        write_reg(REG_DEST_COL, 3'(dc));
        cfg_we <= 1'b0;
    endtask

    task automatic fill_grid(int pct_open);
        for (int i = 0; i < 64; i++)
            load_cell(i / 8, i % 8, $urandom_range(99) < pct_open);
    endtask

    // directed rows: opcode, row, col, open
    typedef struct {
        logic op;
        int r;
        int c;
        bit o;
    } dir_row_t;

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (path_q.size() == 0)
            begin
                errors++;
                if (mism++ < 10) $display("unexpected beat %p", out_data);
            end
            else
            begin
                out_item_t e;
                e = path_q.pop_front();
                if (e !== out_data)
                begin
                    errors++;
                    if (mism++ < 10)
                        $display("mismatch: expected %p actual %p", e, out_data);
                end
            end
        end
    end

    // receiver stall; the long hold outlasts a whole search so the path backs up
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (8000) @(posedge clk);
                long_hold = 0;
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 3000000)
            begin
                $display("FAIL grid_astar_path_search");
                $finish;
            end
        end
    end

    initial
    begin
        dir_row_t rows [$];
        int n_items;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_START_ROW;
        cfg_data = '0;
        errors = 0;
        mism = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold = 0;
        p_srow = 0; p_scol = 0; p_drow = 7; p_dcol = 7;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // open grid, reset route (0,0)->(7,7): diagonal path
        fill_grid(100);
        rows.push_back('{OP_RUN, 0, 0, 0});
        rows.push_back('{OP_LOAD, 7, 7, 0});      // blocked destination
        rows.push_back('{OP_RUN, 7, 0, 1});
        rows.push_back('{OP_LOAD, 7, 7, 1});
        rows.push_back('{OP_LOAD, 3, 3, 0});
        rows.push_back('{OP_LOAD, 0, 0, 0});      // start passable bit unchecked
        rows.push_back('{OP_RUN, 0, 7, 0});
        rows.push_back('{OP_LOAD, 0, 0, 1});
        rows.push_back('{OP_LOAD, 3, 3, 1});
        foreach (rows[i])
        begin
            in_item_t it;
            it.opcode = rows[i].op;
            it.cell_row = 3'(rows[i].r);
            it.cell_col = 3'(rows[i].c);
            it.cell_open = rows[i].o;
            send_item(it);
        end
        set_route(4, 4, 4, 4);                    // start equals destination
        path_q.push_back(mk(4, 4, 1, 1));
        run_search();
        path_q.delete(path_q.size() - 1);
        set_route(7, 7, 0, 0);
        run_search();
        // diagonal through a blocked corner pair
        load_cell(1, 0, 0);
        load_cell(0, 1, 0);
        set_route(1, 1, 0, 0);
        run_search();
        // walled-off destination: not found
        set_route(0, 0, 7, 7);
        load_cell(6, 6, 0);
        load_cell(6, 7, 0);
        load_cell(7, 6, 0);
        run_search();

        n_items = 0;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 70; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 70; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            if (ph == 1)
                set_route(0, 0, 7, 7);
            else if (ph == 4)
                set_route(7, 7, 0, 0);
            else
                set_route($urandom_range(7), $urandom_range(7),
                          $urandom_range(7), $urandom_range(7));
            fill_grid($urandom_range(60, 95));
            n_items += 64;
            if (ph == 2) long_hold = 1;
            for (int j = 0; j < 4; j++)
            begin
                if (j == 2)
                    set_route($urandom_range(7), $urandom_range(7),
                              $urandom_range(7), $urandom_range(7));
                run_search();
                repeat ($urandom_range(3)) load_cell($urandom_range(7),
                    $urandom_range(7), $urandom_range(99) < 75);
            end
        end

        drain();
        if (errors == 0 && path_q.size() == 0)
            $display("PASS grid_astar_path_search");
        else
            $display("FAIL grid_astar_path_search");
        $finish;
    end
endmodule
`default_nettype wire
